>>> design/gdda_pkg.sv
// package: payload types, register indexes and constants of the grid ray caster
package gdda_pkg;

   localparam int MAP_SIDE    = 64;
   localparam int CELL_BITS   = 6;
   localparam int FRAC_BITS   = 10;
   localparam int ANGLE_BITS  = 12;
   localparam int CFG_BITS    = 7;
   localparam int MAP_CELLS   = MAP_SIDE * MAP_SIDE;
   localparam int ADDR_BITS   = 2 * CELL_BITS;

   localparam logic [1:0] CSR_MAP_WIDTH    = 2'd0;
   localparam logic [1:0] CSR_MAP_HEIGHT   = 2'd1;
   localparam logic [1:0] CSR_MAX_DISTANCE = 2'd2;

   localparam logic [CFG_BITS-1:0] MAP_WIDTH_RST    = 7'd64;
   localparam logic [CFG_BITS-1:0] MAP_HEIGHT_RST   = 7'd64;
   localparam logic [CFG_BITS-1:0] MAX_DISTANCE_RST = 7'd16;

   localparam logic [17:0] INC_MAX  = 18'h3FFFF;
   localparam logic [16:0] DIST_MAX = 17'h1FFFF;
   localparam logic [16:0] ONE_Q16  = 17'd65536;

   typedef struct packed {
      logic        mode;
      logic [5:0]  cell_x;
      logic [5:0]  cell_y;
      logic        cell_wall;
      logic [15:0] player_x;
      logic [15:0] player_y;
      logic [11:0] ray_angle;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [16:0] distance;
      logic [15:0] hit_x;
      logic [15:0] hit_y;
      logic [5:0]  hit_cell_x;
      logic [5:0]  hit_cell_y;
   } rsp_type;

   // sine polynomial coefficients, innermost first after the constant term
   function automatic logic [16:0] sine_coef(input logic [1:0] idx);
      logic [16:0] c;
      case (idx)
         2'd0:    c = 17'd307;
         2'd1:    c = 17'd5223;
         2'd2:    c = 17'd42334;
         2'd3:    c = 17'd102944;
         default: c = 17'd0;
      endcase
      return c;
   endfunction

endpackage

>>> design/grid_dda_ray_cast_core.sv
// top level: grid ray caster with map store, shared multiplier and divider
//
// A request is taken when start is high and busy is low. Mode 0 writes one
// map cell in the same cycle and gives no result. Mode 1 casts a ray and
// gives exactly one result on rsp_data, marked by rsp_valid for one cycle.
// The receiver cannot hold a result off; the next request is taken in the
// cycle the result is shown.
// A cast evaluates the sine polynomial (one shared 20x18 multiplier, product
// registered), the two reciprocals (one radix-2 divider, one quotient bit a
// cycle), the end cell and first partial rays, then crosses map cells (one
// map read port, read registered) and on a hit works out the hit point.
// The user must write the registers through csr_we, csr_addr, csr_wdata
// only while idle; the block itself does not enforce it. After reset the
// map is cleared to open in one pass, one cell a cycle, with busy high;
// register writes are taken meanwhile.
module grid_dda_ray_cast_core
   import gdda_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  req_type             req_data,
   output logic                rsp_valid,
   output rsp_type             rsp_data,
   input  logic                csr_we,
   input  logic [1:0]          csr_addr,
   input  logic [CFG_BITS-1:0] csr_wdata
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CLEAR = 4'd1;
   localparam logic [3:0] S_SIN   = 4'd2;
   localparam logic [3:0] S_DIR   = 4'd3;
   localparam logic [3:0] S_DIV   = 4'd4;
   localparam logic [3:0] S_SETUP = 4'd5;
   localparam logic [3:0] S_LOOK  = 4'd6;
   localparam logic [3:0] S_CHECK = 4'd7;
   localparam logic [3:0] S_HIT   = 4'd8;

   localparam logic [4:0] DIV_LAST = 5'd26;

   logic [3:0]           state_ff, state_in;
   logic [3:0]           k_ff, k_in;
   logic                 sel_ff, sel_in;
   logic [ADDR_BITS-1:0] clr_ff, clr_in;
   logic [15:0]          px_ff, px_in, py_ff, py_in;
   logic [11:0]          ang_ff, ang_in;
   logic [16:0]          t2_ff, t2_in, acc_ff, acc_in;
   logic [16:0]          up_ff, up_in, down_ff, down_in;
   logic [16:0]          mx_ff, mx_in, my_ff, my_in;
   logic                 posx_ff, posx_in, posy_ff, posy_in;
   logic [17:0]          rem_ff, rem_in;
   logic [26:0]          quo_ff, quo_in;
   logic [4:0]           cnt_ff, cnt_in;
   logic [17:0]          incx_ff, incx_in, incy_ff, incy_in;
   logic [9:0]           ex_ff, ex_in, ey_ff, ey_in;
   logic [19:0]          partx_ff, partx_in, party_ff, party_in;
   logic [19:0]          dist_ff, dist_in;
   logic [7:0]           cx_ff, cx_in, cy_ff, cy_in;
   logic [37:0]          prod_ff;
   logic [15:0]          hx_ff, hx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;
   logic [CFG_BITS-1:0]  width_ff, width_in, height_ff, height_in, maxd_ff, maxd_in;

   logic                 map_mem [MAP_CELLS];
   logic                 rd_ff;

   logic [19:0]          mul_a;
   logic [17:0]          mul_b;
   logic [37:0]          prod;
   logic [16:0]          t_val, t_base;
   logic [17:0]          sin_raw;
   logic [16:0]          sin_res;
   logic [16:0]          div_m;
   logic [17:0]          rem_sh;
   logic                 div_ge;
   logic [26:0]          quo_next;
   logic [10:0]          fx, fy;
   logic [16:0]          mag;
   logic [19:0]          to_val;
   logic [38:0]          ofs_sum;
   logic [22:0]          ofs;
   logic [24:0]          coord;
   logic [15:0]          coord_clip;
   logic [CFG_BITS-1:0]  w_use, h_use;
   logic                 outside, hit_now, dest, far;
   logic [16:0]          limit;
   logic                 accept;
   logic                 mem_we;
   logic [ADDR_BITS-1:0] mem_waddr;
   logic                 mem_wdata;

   assign accept    = start && !busy;
   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign t_base = {1'b0, ang_ff[9:0], 6'b0};
   assign t_val  = sel_ff ? (ONE_Q16 - t_base) : t_base;
   assign fx     = posx_ff ? (11'd1024 - {1'b0, px_ff[9:0]}) : {1'b0, px_ff[9:0]};
   assign fy     = posy_ff ? (11'd1024 - {1'b0, py_ff[9:0]}) : {1'b0, py_ff[9:0]};
   assign w_use  = (width_ff > 7'd64) ? 7'd64 : width_ff;
   assign h_use  = (height_ff > 7'd64) ? 7'd64 : height_ff;
   assign limit  = {maxd_ff, 10'b0};

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_SIN: begin
            mul_a = (k_ff == 4'd0) ? {3'b0, t_val} : {3'b0, acc_ff};
            mul_b = (k_ff == 4'd0 || k_ff == 4'd10) ? {1'b0, t_val} : {1'b0, t2_ff};
         end
         S_SETUP: begin
            case (k_ff[2:1])
               2'd0:    begin mul_a = {13'b0, maxd_ff}; mul_b = {1'b0, mx_ff}; end
               2'd1:    begin mul_a = {13'b0, maxd_ff}; mul_b = {1'b0, my_ff}; end
               2'd2:    begin mul_a = {9'b0, fx}; mul_b = incx_ff; end
               default: begin mul_a = {9'b0, fy}; mul_b = incy_ff; end
            endcase
         end
         S_HIT: begin
            mul_a = dist_ff;
            mul_b = k_ff[1] ? {1'b0, my_ff} : {1'b0, mx_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   assign sin_raw = prod_ff[33:16];
   assign sin_res = (sin_raw > {1'b0, ONE_Q16}) ? ONE_Q16 : sin_raw[16:0];

   assign div_m    = sel_ff ? my_ff : mx_ff;
   assign rem_sh   = {rem_ff[16:0], (cnt_ff == 5'd0)};
   assign div_ge   = (rem_sh >= {1'b0, div_m});
   assign quo_next = {quo_ff[25:0], div_ge};

   assign mag    = prod_ff[22:6];
   assign to_val = (k_ff[1] ? posy_ff : posx_ff)
                   ? ({4'b0, (k_ff[1] ? py_ff : px_ff)} + {3'b0, mag})
                   : ({4'b0, (k_ff[1] ? py_ff : px_ff)} - {3'b0, mag});

   assign ofs_sum = {1'b0, prod_ff} + 39'd32768;
   assign ofs     = ofs_sum[38:16];
   assign coord   = (k_ff[1] ? posy_ff : posx_ff)
                    ? ({9'b0, (k_ff[1] ? py_ff : px_ff)} + {2'b0, ofs})
                    : ({9'b0, (k_ff[1] ? py_ff : px_ff)} - {2'b0, ofs});
   assign coord_clip = coord[24] ? 16'd0 : ((|coord[23:16]) ? 16'hFFFF : coord[15:0]);

   assign outside = cx_ff[7] || ($signed(cx_ff) >= $signed({1'b0, w_use}))
                 || cy_ff[7] || ($signed(cy_ff) >= $signed({1'b0, h_use}));
   assign hit_now = !outside && rd_ff;
   assign dest    = ({{2{cx_ff[7]}}, cx_ff} == ex_ff) && ({{2{cy_ff[7]}}, cy_ff} == ey_ff);
   assign far     = (dist_ff >= {3'b0, limit});

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      sel_in       = sel_ff;
      clr_in       = clr_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      ang_in       = ang_ff;
      t2_in        = t2_ff;
      acc_in       = acc_ff;
      up_in        = up_ff;
      down_in      = down_ff;
      mx_in        = mx_ff;
      my_in        = my_ff;
      posx_in      = posx_ff;
      posy_in      = posy_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      incx_in      = incx_ff;
      incy_in      = incy_ff;
      ex_in        = ex_ff;
      ey_in        = ey_ff;
      partx_in     = partx_ff;
      party_in     = party_ff;
      dist_in      = dist_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      hx_in        = hx_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      maxd_in      = maxd_ff;
      mem_we       = 1'b0;
      mem_waddr    = {req_data.cell_y, req_data.cell_x};
      mem_wdata    = req_data.cell_wall;

      if (csr_we) begin
         case (csr_addr)
            CSR_MAP_WIDTH:    width_in  = csr_wdata;
            CSR_MAP_HEIGHT:   height_in = csr_wdata;
            CSR_MAX_DISTANCE: maxd_in   = csr_wdata;
            default:          ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (!req_data.mode) begin
                  mem_we = 1'b1;
               end else begin
                  px_in    = req_data.player_x;
                  py_in    = req_data.player_y;
                  ang_in   = req_data.ray_angle;
                  cx_in    = {2'b0, req_data.player_x[15:10]};
                  cy_in    = {2'b0, req_data.player_y[15:10]};
                  dist_in  = '0;
                  k_in     = '0;
                  sel_in   = 1'b0;
                  acc_in   = 17'd11;
                  state_in = S_SIN;
               end
            end
         end
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = 1'b0;
            clr_in    = clr_ff + 1'b1;
            if (&clr_ff) begin
               state_in = S_IDLE;
            end
         end
         S_SIN: begin
            k_in = k_ff + 1'b1;
            if (k_ff == 4'd1) begin
               t2_in = prod_ff[32:16];
            end else if (k_ff == 4'd11) begin
               k_in   = '0;
               acc_in = 17'd11;
               if (!sel_ff) begin
                  up_in  = sin_res;
                  sel_in = 1'b1;
               end else begin
                  down_in  = sin_res;
                  state_in = S_DIR;
               end
            end else if (k_ff[0]) begin
               acc_in = sine_coef(k_ff[2:1] - 2'd1) - prod_ff[32:16];
            end
         end
         S_DIR: begin
            case (ang_ff[11:10])
               2'd0: begin
                  mx_in = down_ff; posx_in = (down_ff != 17'd0);
                  my_in = up_ff;   posy_in = (up_ff != 17'd0);
               end
               2'd1: begin
                  mx_in = up_ff;   posx_in = 1'b0;
                  my_in = down_ff; posy_in = (down_ff != 17'd0);
               end
               2'd2: begin
                  mx_in = down_ff; posx_in = 1'b0;
                  my_in = up_ff;   posy_in = 1'b0;
               end
               default: begin
                  mx_in = up_ff;   posx_in = (up_ff != 17'd0);
                  my_in = down_ff; posy_in = 1'b0;
               end
            endcase
            sel_in   = 1'b0;
            cnt_in   = '0;
            rem_in   = '0;
            quo_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            rem_in = div_ge ? (rem_sh - {1'b0, div_m}) : rem_sh;
            quo_in = quo_next;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               cnt_in = '0;
               rem_in = '0;
               quo_in = '0;
               if (!sel_ff) begin
                  incx_in = (|quo_next[26:18]) ? INC_MAX : quo_next[17:0];
                  sel_in  = 1'b1;
               end else begin
                  incy_in  = (|quo_next[26:18]) ? INC_MAX : quo_next[17:0];
                  k_in     = '0;
                  state_in = S_SETUP;
               end
            end
         end
         S_SETUP: begin
            k_in = k_ff + 1'b1;
            case (k_ff)
               4'd1:    ex_in    = to_val[19:10];
               4'd3:    ey_in    = to_val[19:10];
               4'd5:    partx_in = prod_ff[29:10];
               4'd7: begin
                  party_in = prod_ff[29:10];
                  state_in = S_LOOK;
               end
               default: ;
            endcase
         end
         S_LOOK: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (hit_now) begin
               k_in     = '0;
               state_in = S_HIT;
            end else if (outside || dest || far) begin
               rsp_in       = '0;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               if (partx_ff < party_ff) begin
                  cx_in    = posx_ff ? (cx_ff + 8'd1) : (cx_ff - 8'd1);
                  dist_in  = partx_ff;
                  partx_in = partx_ff + {2'b0, incx_ff};
               end else begin
                  cy_in    = posy_ff ? (cy_ff + 8'd1) : (cy_ff - 8'd1);
                  dist_in  = party_ff;
                  party_in = party_ff + {2'b0, incy_ff};
               end
               state_in = S_LOOK;
            end
         end
         S_HIT: begin
            k_in = k_ff + 1'b1;
            if (k_ff == 4'd1) begin
               hx_in = coord_clip;
            end else if (k_ff == 4'd3) begin
               rsp_in.hit        = 1'b1;
               rsp_in.distance   = (|dist_ff[19:17]) ? DIST_MAX : dist_ff[16:0];
               rsp_in.hit_x      = hx_ff;
               rsp_in.hit_y      = coord_clip;
               rsp_in.hit_cell_x = cx_ff[5:0];
               rsp_in.hit_cell_y = cy_ff[5:0];
               rsp_valid_in      = 1'b1;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         k_ff         <= '0;
         sel_ff       <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         width_ff     <= MAP_WIDTH_RST;
         height_ff    <= MAP_HEIGHT_RST;
         maxd_ff      <= MAX_DISTANCE_RST;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         k_ff         <= k_in;
         sel_ff       <= sel_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         maxd_ff      <= maxd_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff    <= px_in;
      py_ff    <= py_in;
      ang_ff   <= ang_in;
      t2_ff    <= t2_in;
      acc_ff   <= acc_in;
      up_ff    <= up_in;
      down_ff  <= down_in;
      mx_ff    <= mx_in;
      my_ff    <= my_in;
      posx_ff  <= posx_in;
      posy_ff  <= posy_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      incx_ff  <= incx_in;
      incy_ff  <= incy_in;
      ex_ff    <= ex_in;
      ey_ff    <= ey_in;
      partx_ff <= partx_in;
      party_ff <= party_in;
      dist_ff  <= dist_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      hx_ff    <= hx_in;
      prod_ff  <= prod;
      rsp_ff   <= rsp_in;
   end

   // map store, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= map_mem[{cy_ff[5:0], cx_ff[5:0]}];
   end

   a_clear_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> busy)
      else $error("map clear pass not running after reset");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_strobe_when_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while a request is still in work");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.hit) |-> (rsp_data.distance == 17'd0 &&
      rsp_data.hit_x == 16'd0 && rsp_data.hit_y == 16'd0))
      else $error("miss result not cleared");

endmodule
